FILE: rtl/core/dcas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcas_pkg
// Shared types, codes and helpers of the dma channel address sequencer.
// ----------------------------------------------------------------------------
package dcas_pkg;

  // item kinds on the input side
  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_TRIG = 2'd1,
    MODE_STEP = 2'd2,
    MODE_OFF  = 2'd3
  } mode_t;

  // answer codes on the result side
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_XFER = 2'd1,
    ST_WAIT = 2'd2,
    ST_OFF  = 2'd3
  } status_t;

  // address control codes
  localparam logic [1:0] ACTL_INC    = 2'd0;
  localparam logic [1:0] ACTL_DEC    = 2'd1;
  localparam logic [1:0] ACTL_FIXED  = 2'd2;
  localparam logic [1:0] ACTL_RELOAD = 2'd3;

  localparam logic [1:0]  LAST_CH    = 2'd3;
  localparam logic [2:0]  NO_CHANNEL = 3'd4;
  localparam logic [27:0] MASK27     = 28'h7FF_FFFF;
  localparam logic [27:0] MASK28     = 28'hFFF_FFFF;
  localparam logic [16:0] FULL_COUNT = 17'h1_0000;

  // queue between front and back, depth a power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // one classified word handed from front to back
  typedef struct packed {
    mode_t       mode;
    logic [1:0]  ch;
    logic [27:0] src_ptr;     // aligned and masked
    logic [27:0] dst_ptr;     // aligned and masked
    logic [27:0] dst_reload;  // raw register value
    logic [16:0] count;       // count after the channel's cap rule
    logic        word;
    logic [1:0]  src_ctrl;
    logic [1:0]  dst_ctrl;
    logic        rep;
    logic        irq;
    logic        start_now;
    logic        sound;
  } cmd_t;

  function automatic logic [27:0] src_mask(input logic [1:0] ch);
    src_mask = (ch == 2'd0) ? MASK27 : MASK28;
  endfunction

  function automatic logic [27:0] dst_mask(input logic [1:0] ch);
    dst_mask = (ch == LAST_CH) ? MASK28 : MASK27;
  endfunction

  function automatic logic [27:0] align_addr(input logic [27:0] a, input logic word);
    align_addr = word ? {a[27:2], 2'b00} : {a[27:1], 1'b0};
  endfunction

  // rom area always counts up, otherwise the control field decides
  function automatic logic [27:0] move_addr(input logic [27:0] a, input logic [1:0] ctl,
                                           input logic [27:0] step,
                                           input logic [27:0] mask);
    logic rom;
    rom = (a[27:24] >= 4'd8) && (a[27:24] <= 4'd13);
    if (rom || ctl == ACTL_INC || ctl == ACTL_RELOAD) begin
      move_addr = (a + step) & mask;
    end else if (ctl == ACTL_DEC) begin
      move_addr = (a - step) & mask;
    end else begin
      move_addr = a & mask;
    end
  endfunction

endpackage

FILE: rtl/core/dcas_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcas_front
// Accepts input words, works out the capped count and the aligned pointers,
// and pushes one classified command into the queue.
// ----------------------------------------------------------------------------
module dcas_front #(
  parameter int COUNT_CAP = 16384
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [87:0]   in_tdata,
  input  logic [3:0]    in_tuser,
  input  logic          q_full,
  output logic          q_push,
  output dcas_pkg::cmd_t q_cmd
);
  import dcas_pkg::*;

  // ceil(2^32 / cap): exact quotient for any 16 bit count
  localparam logic [32:0] CAP_RECIP =
    33'(((64'd1 << 32) + 64'(COUNT_CAP) - 64'd1) / 64'(COUNT_CAP));
  localparam logic [16:0] CAP_VAL = 17'(COUNT_CAP);

  logic        s1_valid_r, s1_valid_nxt;
  logic [87:0] s1_data_r;
  logic [3:0]  s1_user_r;
  logic [48:0] prod_r;

  logic        in_fire;
  logic [15:0] ct;
  logic [15:0] quot;
  logic [15:0] rem;
  logic [1:0]  ch;
  logic        word;

  assign in_tready = !s1_valid_r || !q_full;
  assign in_fire   = in_tvalid && in_tready;
  assign q_push    = s1_valid_r && !q_full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_tdata;
      s1_user_r <= in_tuser;
      prod_r    <= 49'(in_tdata[71:56]) * 49'(CAP_RECIP);
    end
  end

  assign ct   = s1_data_r[71:56];
  assign quot = prod_r[47:32];
  assign rem  = 16'(32'(ct) - 32'(quot) * 32'(CAP_VAL));
  assign ch   = s1_user_r[3:2];
  assign word = s1_data_r[72];

  always_comb begin
    q_cmd.mode       = mode_t'(s1_user_r[1:0]);
    q_cmd.ch         = ch;
    q_cmd.src_ptr    = align_addr(s1_data_r[27:0], word) & src_mask(ch);
    q_cmd.dst_ptr    = align_addr(s1_data_r[55:28], word) & dst_mask(ch);
    q_cmd.dst_reload = s1_data_r[55:28];
    if (ch == LAST_CH) begin
      q_cmd.count = (ct == 16'd0) ? FULL_COUNT : {1'b0, ct};
    end else begin
      q_cmd.count = (rem == 16'd0) ? CAP_VAL : {1'b0, rem};
    end
    q_cmd.word      = word;
    q_cmd.src_ctrl  = s1_data_r[74:73];
    q_cmd.dst_ctrl  = s1_data_r[76:75];
    q_cmd.rep       = s1_data_r[77];
    q_cmd.irq       = s1_data_r[78];
    q_cmd.start_now = (s1_data_r[80:79] == 2'd0);
    q_cmd.sound     = s1_data_r[81];
  end

endmodule

FILE: rtl/core/dcas_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcas_fifo
// Short command queue that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
module dcas_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dcas_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output dcas_pkg::cmd_t head
);
  import dcas_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/core/dcas_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcas_back
// Per-channel register file and sequencer: carries out one command a cycle
// unless an answer waits for out_tready, and holds it in the output register.
// ----------------------------------------------------------------------------
module dcas_back #(
  parameter int COUNT_CAP = 16384
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  dcas_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [63:0]    out_tdata,
  output logic [1:0]     out_tuser,
  output logic           out_tlast
);
  import dcas_pkg::*;

  // sound run of four words through the cap rule of the low channels
  localparam int          SND_MOD = 4 % COUNT_CAP;
  localparam logic [16:0] SND_CNT_LO = (SND_MOD == 0) ? 17'(COUNT_CAP) : 17'(SND_MOD);
  localparam logic [16:0] SND_CNT_HI = 17'd4;

  // per-channel state
  logic [27:0] src_r [4];
  logic [27:0] dst_r [4];
  logic [27:0] reload_r [4];
  logic [16:0] cnt_reload_r [4];
  logic [16:0] rem_r [4];
  logic [1:0]  sctl_r [4];
  logic [1:0]  dctl_r [4];
  logic        en_r [4];
  logic        word_r [4];
  logic        rep_r [4];
  logic        irq_r [4];
  logic        snd_r [4];
  logic        first_r [4];
  logic [2:0]  active_r, active_nxt;

  // next values of the addressed channel
  logic [27:0] src_nxt, dst_nxt;
  logic [16:0] rem_nxt;
  logic        en_nxt, snd_nxt, first_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  status_t     status_r, status_nxt;
  logic [27:0] raddr_r, raddr_nxt;
  logic [27:0] waddr_r, waddr_nxt;
  logic        is_word_r, is_word_nxt;
  logic        first_acc_r, first_acc_nxt;
  logic        last_r, last_nxt;
  logic        irq_out_r, irq_out_nxt;
  logic        pend_r, pend_nxt;

  logic        exec;
  logic [1:0]  ch;
  logic [16:0] rem_dec;
  logic [27:0] step;

  assign exec    = q_valid && (!out_valid_r || out_tready);
  assign q_pop   = exec;
  assign ch      = q_cmd.ch;
  assign rem_dec = rem_r[ch] - 17'd1;
  assign step    = (word_r[ch] || snd_r[ch]) ? 28'd4 : 28'd2;

  always_comb begin
    src_nxt       = src_r[ch];
    dst_nxt       = dst_r[ch];
    rem_nxt       = rem_r[ch];
    en_nxt        = en_r[ch];
    snd_nxt       = snd_r[ch];
    first_nxt     = first_r[ch];
    active_nxt    = active_r;
    status_nxt    = ST_IDLE;
    raddr_nxt     = '0;
    waddr_nxt     = '0;
    is_word_nxt   = 1'b0;
    first_acc_nxt = 1'b0;
    last_nxt      = 1'b0;
    irq_out_nxt   = 1'b0;
    pend_nxt      = 1'b0;
    unique case (q_cmd.mode)
      MODE_LOAD: begin
        en_nxt    = 1'b1;
        src_nxt   = q_cmd.src_ptr;
        dst_nxt   = q_cmd.dst_ptr;
        snd_nxt   = 1'b0;
        first_nxt = 1'b1;
        rem_nxt   = q_cmd.start_now ? q_cmd.count : 17'd0;
        pend_nxt  = q_cmd.start_now;
      end
      MODE_OFF: begin
        en_nxt  = 1'b0;
        rem_nxt = 17'd0;
        snd_nxt = 1'b0;
        if (active_r == {1'b0, ch}) begin
          active_nxt = NO_CHANNEL;
        end
      end
      MODE_TRIG: begin
        if (!en_r[ch]) begin
          status_nxt = ST_OFF;
        end else begin
          if (dctl_r[ch] == ACTL_RELOAD) begin
            dst_nxt = align_addr(reload_r[ch], word_r[ch]) & dst_mask(ch);
          end
          snd_nxt   = q_cmd.sound;
          first_nxt = 1'b1;
          if (q_cmd.sound) begin
            rem_nxt = (ch == LAST_CH) ? SND_CNT_HI : SND_CNT_LO;
          end else begin
            rem_nxt = cnt_reload_r[ch];
          end
        end
      end
      MODE_STEP: begin
        if (!en_r[ch]) begin
          status_nxt = ST_OFF;
        end else if (rem_r[ch] == 17'd0) begin
          status_nxt = ST_IDLE;
        end else if ({1'b0, ch} > active_r) begin
          status_nxt = ST_WAIT;
        end else begin
          status_nxt    = ST_XFER;
          raddr_nxt     = src_r[ch];
          waddr_nxt     = dst_r[ch];
          is_word_nxt   = word_r[ch] || snd_r[ch];
          first_acc_nxt = first_r[ch];
          src_nxt       = move_addr(src_r[ch], sctl_r[ch], step, src_mask(ch));
          if (!snd_r[ch]) begin
            dst_nxt = move_addr(dst_r[ch], dctl_r[ch], step, dst_mask(ch));
          end
          first_nxt  = 1'b0;
          rem_nxt    = rem_dec;
          active_nxt = {1'b0, ch};
          if (rem_dec == 17'd0) begin
            last_nxt    = 1'b1;
            irq_out_nxt = irq_r[ch];
            snd_nxt     = 1'b0;
            active_nxt  = NO_CHANNEL;
            if (!rep_r[ch]) begin
              en_nxt = 1'b0;
            end
          end
        end
      end
      default: begin
        status_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        en_r[i]    <= 1'b0;
        rem_r[i]   <= '0;
        snd_r[i]   <= 1'b0;
        first_r[i] <= 1'b0;
      end
      active_r    <= NO_CHANNEL;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (exec) begin
        en_r[ch]    <= en_nxt;
        rem_r[ch]   <= rem_nxt;
        snd_r[ch]   <= snd_nxt;
        first_r[ch] <= first_nxt;
        active_r    <= active_nxt;
      end
    end
  end

  // pointers, latched settings and the answer
  always_ff @(posedge clk) begin
    if (exec) begin
      src_r[ch] <= src_nxt;
      dst_r[ch] <= dst_nxt;
      if (q_cmd.mode == MODE_LOAD) begin
        reload_r[ch]     <= q_cmd.dst_reload;
        cnt_reload_r[ch] <= q_cmd.count;
        word_r[ch]       <= q_cmd.word;
        sctl_r[ch]       <= q_cmd.src_ctrl;
        dctl_r[ch]       <= q_cmd.dst_ctrl;
        rep_r[ch]        <= q_cmd.rep;
        irq_r[ch]        <= q_cmd.irq;
      end
      status_r    <= status_nxt;
      raddr_r     <= raddr_nxt;
      waddr_r     <= waddr_nxt;
      is_word_r   <= is_word_nxt;
      first_acc_r <= first_acc_nxt;
      last_r      <= last_nxt;
      irq_out_r   <= irq_out_nxt;
      pend_r      <= pend_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {4'd0, pend_r, irq_out_r, first_acc_r, is_word_r, waddr_r, raddr_r};

  // a transfer is only ever issued from an armed run
  a_xfer_armed: assert property (@(posedge clk) disable iff (!rst_n)
    exec && status_nxt == ST_XFER |-> rem_r[ch] != 17'd0)
    else $error("transfer issued on a channel with no words left");

  // a run in progress owns the active slot afterwards
  a_slot_held: assert property (@(posedge clk) disable iff (!rst_n)
    exec && status_nxt == ST_XFER && !last_nxt |=> active_r[1:0] == $past(ch) && !active_r[2])
    else $error("active slot not held by the running channel");

  // active slot holds a channel number or the free code
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r[2] |-> active_r[1:0] == 2'd0)
    else $error("active slot holds an invalid code");

  // end of run is only flagged on an issued transfer
  a_last_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && last_r |-> status_r == ST_XFER)
    else $error("run end flagged without a transfer");

endmodule

FILE: rtl/core/dma_channel_address_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_channel_address_sequencer
// Four-channel dma address and count sequencer with a decoupled front end.
// ----------------------------------------------------------------------------
// usage
// - in_* carries command words: tuser selects the kind (load and enable,
//   trigger, transfer step, disable) and the channel, tdata the register
//   values latched on a load and the sound flag sampled on a trigger
// - out_* returns exactly one answer word per command: tuser is the status,
//   tdata the transfer addresses and flags, tlast marks the run's last transfer
// - the accepted word and the count reciprocal product are registered in the
//   front stage, the classified command is then registered in the queue and
//   the answer after that in the back's output register
// - throughput is one command per cycle while out_tready is high, set by the
//   back's single read and update of one channel's registers per cycle
// - when out_tready is low the answer holds, the back stops, the two-entry
//   queue fills and in_tready drops once the front stage is also held
// - reset (rst_n low, synchronous) disables all channels, clears counts and
//   frees the active slot; no clearing pass is needed
// ----------------------------------------------------------------------------
module dma_channel_address_sequencer #(
  parameter int COUNT_CAP = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // src_addr[27:0] dst_addr[55:28] word_count[71:56] word_size[72]
  // src_ctrl[74:73] dst_ctrl[76:75] repeat_mode[77] irq_enable[78]
  // start_timing[80:79] sound_mode[81] zero pad[87:82]
  input  logic [87:0] in_tdata,
  // mode[1:0] channel[3:2]
  input  logic [3:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_addr[27:0] write_addr[55:28] is_word[56] first_access[57]
  // raise_irq[58] start_pending[59] zero pad[63:60]
  output logic [63:0] out_tdata,
  // status[1:0]
  output logic [1:0]  out_tuser,
  // last
  output logic        out_tlast
);
  import dcas_pkg::*;

  // front to queue
  logic q_push;
  cmd_t push_cmd;
  logic q_full;

  // queue to back
  logic q_valid;
  logic q_pop;
  cmd_t head_cmd;

  // classify and cap the count
  dcas_front #(
    .COUNT_CAP(COUNT_CAP)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  // decoupling queue
  dcas_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (head_cmd)
  );

  // channel registers and sequencing
  dcas_back #(
    .COUNT_CAP(COUNT_CAP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
